### sv/lkvt_pkg.sv
// Shared types, codes and sizes for the linear key/value table.
package lkvt_pkg;

   // Table geometry
   localparam int CAPACITY   = 16;
   localparam int VALUE_BITS = 32;
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);

   // Field widths of the transaction payloads
   localparam int OP_BITS          = 2;
   localparam int KEY_BITS         = 8;
   localparam int DATA_BITS        = 32;
   localparam int STATUS_BITS      = 2;
   localparam int ENTRY_COUNT_BITS = 5;

   // Request kinds (the unused code is served as a lookup)
   localparam logic [OP_BITS-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OP_BITS-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_BITS-1:0] OP_REMOVE = 2'd2;

   // Response status codes
   localparam logic [STATUS_BITS-1:0] STATUS_DONE      = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd2;

   typedef struct packed {
      logic [OP_BITS-1:0]          op;
      logic [KEY_BITS-1:0]         key;
      logic signed [DATA_BITS-1:0] value;
   } lkvt_req_type;

   typedef struct packed {
      logic                          found;
      logic signed [DATA_BITS-1:0]   read_value;
      logic [STATUS_BITS-1:0]        status;
      logic [ENTRY_COUNT_BITS-1:0]   entry_count;
   } lkvt_rsp_type;

   // Per-cell control from the table controller
   typedef struct packed {
      logic accept;      // transaction taken this cycle
      logic is_insert;
      logic is_remove;
      logic hit_any;     // key present somewhere in the table
      logic occupied;    // this cell lies below the fill count
      logic append_here; // this cell is the first free slot and the key missed
   } lkvt_cell_ctrl_type;

endpackage

### sv/lkvt_cell.sv
// One table entry: key and value storage, key compare and shift-down.
module lkvt_cell
   import lkvt_pkg::*;
(
   input  logic                    clock,
   input  lkvt_cell_ctrl_type      ctrl,
   input  logic [KEY_BITS-1:0]     req_key,
   input  logic [VALUE_BITS-1:0]   req_value,
   input  logic [KEY_BITS-1:0]     next_key,
   input  logic [VALUE_BITS-1:0]   next_value,
   input  logic                    hit_before,
   output logic                    hit_through,
   output logic                    match,
   output logic [KEY_BITS-1:0]     key_out,
   output logic [VALUE_BITS-1:0]   value_out
);

   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [KEY_BITS-1:0]   key_in;
   logic [VALUE_BITS-1:0] value_in;
   logic                  shift_down;

   // Compare against the incoming key; hit chain runs from cell 0 upward
   assign match       = ctrl.occupied && (key_ff == req_key);
   assign hit_through = hit_before || match;

   // Remove closes the gap: this cell and all above the hit pull from above
   assign shift_down = ctrl.is_remove && ctrl.hit_any && hit_through;

   always_comb begin
      key_in   = key_ff;
      value_in = value_ff;
      priority if (shift_down) begin
         key_in   = next_key;
         value_in = next_value;
      end else if (ctrl.is_insert && match) begin
         value_in = req_value;
      end else if (ctrl.is_insert && ctrl.append_here) begin
         key_in   = req_key;
         value_in = req_value;
      end
   end

   // Entry storage, no reset: contents above the count are never read
   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         key_ff   <= key_in;
         value_ff <= value_in;
      end
   end

   assign key_out   = key_ff;
   assign value_out = value_ff;

endmodule

### sv/linear_key_value_table.sv
// A response is registered in the cycle after its request transaction is accepted.
// Throughput: one transaction per cycle; every cell compares in parallel.
// Requests stall only while a finished response is held by rsp_stall.
// Reset clears the fill count and the response valid; entry storage is
// not cleared, since entries above the count are never read.
module linear_key_value_table
   import lkvt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  lkvt_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output lkvt_rsp_type rsp_data
);

   logic                   accept;
   logic                   is_insert;
   logic                   is_remove;
   logic                   is_lookup;
   logic                   hit_any;
   logic                   not_full;
   logic [VALUE_BITS-1:0]  req_value;
   logic [VALUE_BITS-1:0]  hit_value;

   logic [COUNT_BITS-1:0]  count_ff;
   logic [COUNT_BITS-1:0]  count_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   lkvt_rsp_type           rsp_data_ff;
   lkvt_rsp_type           rsp_data_in;

   lkvt_cell_ctrl_type     cell_ctrl  [CAPACITY];
   logic                   hit_chain  [CAPACITY+1];
   logic                   cell_match [CAPACITY];
   logic [KEY_BITS-1:0]    cell_key   [CAPACITY+1];
   logic [VALUE_BITS-1:0]  cell_value [CAPACITY+1];

   // Handshake: the output register frees up when its response is taken
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign is_insert = (req_data.op == OP_INSERT);
   assign is_remove = (req_data.op == OP_REMOVE);
   assign is_lookup = !is_insert && !is_remove;
   assign not_full  = (count_ff < COUNT_BITS'(CAPACITY));
   assign req_value = VALUE_BITS'($unsigned(req_data.value));

   // Chain ends: nothing before cell 0, nothing above the top cell
   assign hit_chain[0]         = 1'b0;
   assign cell_key[CAPACITY]   = '0;
   assign cell_value[CAPACITY] = '0;
   assign hit_any              = hit_chain[CAPACITY];

   // Row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign cell_ctrl[i].accept      = accept;
      assign cell_ctrl[i].is_insert   = is_insert;
      assign cell_ctrl[i].is_remove   = is_remove;
      assign cell_ctrl[i].hit_any     = hit_any;
      assign cell_ctrl[i].occupied    = (COUNT_BITS'(i) < count_ff);
      assign cell_ctrl[i].append_here = !hit_any && (COUNT_BITS'(i) == count_ff);

      lkvt_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl[i]),
         .req_key     (req_data.key),
         .req_value   (req_value),
         .next_key    (cell_key[i+1]),
         .next_value  (cell_value[i+1]),
         .hit_before  (hit_chain[i]),
         .hit_through (hit_chain[i+1]),
         .match       (cell_match[i]),
         .key_out     (cell_key[i]),
         .value_out   (cell_value[i])
      );
   end

   // Value of the hit cell; keys are unique so at most one cell matches
   always_comb begin
      hit_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         hit_value = hit_value | (cell_match[i] ? cell_value[i] : '0);
      end
   end

   // Fill count and response
   always_comb begin
      count_in                = count_ff;
      rsp_data_in.found       = hit_any;
      rsp_data_in.read_value  = '0;
      rsp_data_in.status      = STATUS_DONE;
      priority if (is_insert) begin
         if (!hit_any) begin
            if (not_full) begin
               count_in = count_ff + COUNT_BITS'(1);
            end else begin
               rsp_data_in.status = STATUS_FULL;
            end
         end
      end else if (is_remove) begin
         if (hit_any) begin
            count_in = count_ff - COUNT_BITS'(1);
         end else begin
            rsp_data_in.status = STATUS_NOT_FOUND;
         end
      end else if (is_lookup) begin
         if (hit_any) begin
            rsp_data_in.read_value = DATA_BITS'(hit_value);
         end else begin
            rsp_data_in.status = STATUS_NOT_FOUND;
         end
      end
      rsp_data_in.entry_count = ENTRY_COUNT_BITS'(count_in);
      rsp_valid_in = accept || req_stall;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   // Response payload register
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### sv/lkvt_checker.sv
// Port-level checks for the linear key/value table, bound to the top level.
module lkvt_checker
   import lkvt_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input lkvt_rsp_type rsp_data
);

   // A held response does not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // Every request transaction yields a response on the next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("request transaction without response");

   // Count never exceeds the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.entry_count <= ENTRY_COUNT_BITS'(CAPACITY))
      else $error("entry count above capacity");

   // A full refusal only happens on a miss with the table full
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == STATUS_FULL |->
         !rsp_data.found && rsp_data.entry_count == ENTRY_COUNT_BITS'(CAPACITY))
      else $error("full status with free space or a hit");

   // Non-zero read data only comes from a hit
   a_read_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.read_value != '0 |-> rsp_data.found)
      else $error("read data without a hit");

endmodule

bind linear_key_value_table lkvt_checker u_lkvt_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

### tb/testbench.sv
// Self-checking testbench for the linear key/value table: shadow table, random traffic, stalls.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import lkvt_pkg::*;

   localparam int CLOCK_PERIOD = 10;
   localparam int RANDOM_ITEMS = 1450;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int TAIL_CYCLES  = 6;

   // The spare op code, served by the block as a lookup
   localparam logic [OP_BITS-1:0] OP_SPARE = 2'd3;

   // Shadow copy of the table: predicts each response and checks it on arrival
   class kv_shadow_table;
      logic [KEY_BITS-1:0]  keys [CAPACITY];
      logic [DATA_BITS-1:0] values [CAPACITY];
      int                   fill;
      lkvt_rsp_type         pending_replies [$];
      int                   mismatches;

      function new();
         fill       = 0;
         mismatches = 0;
      endfunction

      // Apply one accepted request transaction and queue the response it must give
      function void record_request(lkvt_req_type req);
         lkvt_rsp_type reply;
         int           hit_at;
         hit_at = -1;
         for (int i = 0; i < fill; i++) begin
            if (hit_at < 0 && keys[i] == req.key) begin
               hit_at = i;
            end
         end
         reply        = '0;
         reply.found  = (hit_at >= 0);
         reply.status = STATUS_DONE;
         case (req.op)
            OP_INSERT: begin
               if (hit_at >= 0) begin
                  values[hit_at] = req.value;
               end else if (fill < CAPACITY) begin
                  keys[fill]   = req.key;
                  values[fill] = req.value;
                  fill++;
               end else begin
                  reply.status = STATUS_FULL;
               end
            end
            OP_REMOVE: begin
               // later entries close up the hole, order kept
               if (hit_at >= 0) begin
                  for (int i = hit_at; i + 1 < fill; i++) begin
                     keys[i]   = keys[i + 1];
                     values[i] = values[i + 1];
                  end
                  fill--;
               end else begin
                  reply.status = STATUS_NOT_FOUND;
               end
            end
            default: begin
               if (hit_at >= 0) begin
                  reply.read_value = values[hit_at];
               end else begin
                  reply.status = STATUS_NOT_FOUND;
               end
            end
         endcase
         reply.entry_count = ENTRY_COUNT_BITS'(fill);
         pending_replies.push_back(reply);
      endfunction

      // Compare one accepted response transaction with the oldest prediction
      function void check_reply(lkvt_rsp_type got);
         lkvt_rsp_type want;
         if (pending_replies.size() == 0) begin
            $display("%0t ns: response with nothing outstanding, expected none, got %p",
                     $time, got);
            mismatches++;
            return;
         end
         want = pending_replies.pop_front();
         if (got.found !== want.found) begin
            $display("%0t ns: found expected %0d, got %0d", $time, want.found, got.found);
            mismatches++;
         end
         if (got.read_value !== want.read_value) begin
            $display("%0t ns: read_value expected %0d, got %0d",
                     $time, want.read_value, got.read_value);
            mismatches++;
         end
         if (got.status !== want.status) begin
            $display("%0t ns: status expected %0d, got %0d", $time, want.status, got.status);
            mismatches++;
         end
         if (got.entry_count !== want.entry_count) begin
            $display("%0t ns: entry_count expected %0d, got %0d",
                     $time, want.entry_count, got.entry_count);
            mismatches++;
         end
      endfunction
   endclass

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   lkvt_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   lkvt_rsp_type rsp_data;

   kv_shadow_table      shadow;
   logic [KEY_BITS-1:0] key_pool [$];
   int                  cycle_count = 0;

   linear_key_value_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Monitor both channels; values read here are those before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            shadow.record_request(req_data);
         end
         if (rsp_valid && !rsp_stall) begin
            shadow.check_reply(rsp_data);
         end
      end
   end

   // Idle cycles before a request: mostly none, some short, a few long
   function automatic int unsigned pick_gap(bit steady);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 55) begin
         return 0;
      end else if (roll < 85) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic lkvt_req_type make_request(logic [OP_BITS-1:0] op,
                                                 logic [KEY_BITS-1:0] key,
                                                 logic [DATA_BITS-1:0] value);
      lkvt_req_type req;
      req.op    = op;
      req.key   = key;
      req.value = value;
      return req;
   endfunction

   // Offer one request and hold it until the block takes it
   task automatic push_request(lkvt_req_type req, int unsigned gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Hold off the sender until every predicted response has been seen
   task automatic drain_replies();
      req_valid <= 1'b0;
      do @(negedge clock); while (shadow.pending_replies.size() != 0);
      @(posedge clock);
   endtask

   // Response side: free-running stretches, choppy stalls and long holds
   initial begin
      int unsigned span;
      int unsigned style;
      forever begin
         style = $urandom_range(0, 9);
         if (style < 3) begin
            span = $urandom_range(20, 80);
            repeat (span) begin
               @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end else if (style < 8) begin
            span = $urandom_range(10, 50);
            repeat (span) begin
               @(posedge clock);
               rsp_stall <= ($urandom_range(0, 3) == 0);
            end
         end else begin
            span = $urandom_range(5, 40);
            repeat (span) begin
               @(posedge clock);
               rsp_stall <= 1'b1;
            end
         end
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("linear_key_value_table regression: fail");
      $finish;
   end

   // Stimulus
   initial begin
      lkvt_req_type req;
      int unsigned  sent;
      int unsigned  phase_len;
      int unsigned  mix;
      int unsigned  roll;
      int unsigned  insert_pct;
      int unsigned  remove_pct;
      bit           steady;

      shadow = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, extreme keys and values, update, spare op, shifts, full
      push_request(make_request(OP_LOOKUP, 8'h00, 32'h1234_5678), pick_gap(0));
      push_request(make_request(OP_REMOVE, 8'hFF, 32'hFFFF_FFFF), pick_gap(0));
      push_request(make_request(OP_INSERT, 8'h00, 32'h8000_0000), pick_gap(0));
      push_request(make_request(OP_INSERT, 8'hFF, 32'h7FFF_FFFF), pick_gap(0));
      push_request(make_request(OP_SPARE, 8'hFF, 32'h0000_0000), pick_gap(0));
      push_request(make_request(OP_INSERT, 8'h00, 32'hFFFF_FFFF), pick_gap(0));
      push_request(make_request(OP_LOOKUP, 8'h00, 32'h5555_AAAA), pick_gap(0));
      // first entry goes, the one behind it moves into its place
      push_request(make_request(OP_REMOVE, 8'h00, 32'hAAAA_5555), pick_gap(0));
      for (int k = 0; k < CAPACITY - 1; k++) begin
         push_request(make_request(OP_INSERT, KEY_BITS'(8'h20 + k), $urandom), pick_gap(0));
      end
      push_request(make_request(OP_INSERT, 8'h5A, 32'h0BAD_F00D), pick_gap(0));
      push_request(make_request(OP_REMOVE, 8'h27, 32'h0000_0001), pick_gap(0));
      push_request(make_request(OP_LOOKUP, 8'h28, 32'h0000_0000), pick_gap(0));
      drain_replies();

      // Random phases: a small key pool per phase keeps hits frequent
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         key_pool.delete();
         repeat ($urandom_range(2, 28)) key_pool.push_back(KEY_BITS'($urandom));
         mix       = $urandom_range(0, 3);
         steady    = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(40, 160);
         // last phase stops at the item budget
         if (phase_len > RANDOM_ITEMS - sent) begin
            phase_len = RANDOM_ITEMS - sent;
         end
         case (mix)
            0:       begin insert_pct = 60; remove_pct = 15; end
            1:       begin insert_pct = 20; remove_pct = 55; end
            2:       begin insert_pct = 35; remove_pct = 30; end
            default: begin insert_pct = 15; remove_pct = 10; end
         endcase
         repeat (phase_len) begin
            roll = $urandom_range(0, 99);
            if (roll < insert_pct) begin
               req.op = OP_INSERT;
            end else if (roll < insert_pct + remove_pct) begin
               req.op = OP_REMOVE;
            end else if (roll % 8 == 0) begin
               req.op = OP_SPARE;
            end else begin
               req.op = OP_LOOKUP;
            end
            if ($urandom_range(0, 9) < 8) begin
               req.key = key_pool[$urandom_range(0, key_pool.size() - 1)];
            end else begin
               req.key = KEY_BITS'($urandom);
            end
            case ($urandom_range(0, 15))
               0:       req.value = 32'h8000_0000;
               1:       req.value = 32'h7FFF_FFFF;
               2:       req.value = 32'h0000_0000;
               3:       req.value = 32'hFFFF_FFFF;
               default: req.value = $urandom;
            endcase
            push_request(req, pick_gap(steady));
            sent++;
         end
         if ($urandom_range(0, 2) == 0) begin
            drain_replies();
         end
      end

      drain_replies();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (shadow.mismatches == 0) begin
         $display("linear_key_value_table regression: pass");
      end else begin
         $display("linear_key_value_table regression: fail");
      end
      $finish;
   end

endmodule
